// ===== rtl/cmsr_pkg.sv =====
// Package for the contact manifold slot replacer.
// Holds the shared sizes, mode codes and the control structs between the top level
// and the area unit. Depends on nothing.
package cmsr_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int SLOTS          = 4;
   localparam int SLOT_BITS      = 2;
   localparam int DEPTH_BITS     = 16;
   localparam int COUNT_BITS     = 3;
   localparam int MODE_BITS      = 2;
   localparam int RSP_BITS       = 8;

   localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR  = 2'd2;

   typedef struct packed {
      logic start;
   } area_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } area_sts_type;

endpackage

// ===== rtl/cmsr_mul.sv =====
// Registered signed multiplier shared by every step of the area unit.
// Uses no package items.
module cmsr_mul #(
   parameter int WIDTH = 18
) (
   input  logic                      clock,
   input  logic signed [WIDTH-1:0]   op_a,
   input  logic signed [WIDTH-1:0]   op_b,
   output logic signed [2*WIDTH-1:0] prod
);

   logic signed [2*WIDTH-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/cmsr_area.sv =====
// Area unit: the squared cross-product area score of one four-point set.
// Depends on cmsr_pkg and on the shared multiplier cmsr_mul.
module cmsr_area #(
   parameter int COORD_BITS = cmsr_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cmsr_pkg::area_ctl_type       ctl,
   input  logic signed [COORD_BITS-1:0] quad [4][3],
   output cmsr_pkg::area_sts_type       sts,
   output logic [4*COORD_BITS+3:0]      score
);
   import cmsr_pkg::*;

   localparam int DW   = COORD_BITS + 1;
   localparam int MW   = COORD_BITS + 2;
   localparam int PW   = 2 * MW;
   localparam int H    = COORD_BITS + 1;
   localparam int MAGW = 2 * COORD_BITS + 1;
   localparam int SUMW = 4 * COORD_BITS + 4;

   logic [1:0] p_ff, k_ff;
   logic [2:0] op_ff;
   logic       ph_ff, busy_ff, done_ff;
   logic signed [PW-1:0] comp_ff;
   logic [MAGW-1:0]      mag_ff;
   logic [SUMW-1:0]      sum_ff, area_ff;

   logic [1:0] b_idx, c_idx, d_idx, x_idx, y_idx;
   logic signed [DW-1:0] u [3];
   logic signed [DW-1:0] v [3];
   logic signed [MW-1:0] op_a, op_b, hi_op, lo_op;
   logic signed [PW-1:0] prod, diff;
   logic [SUMW-1:0]      prod_w, sum_new;
   logic                 last_term, finish;

   // Pair selection: (p0-p1 x p2-p3), (p0-p2 x p1-p3), (p0-p3 x p1-p2).
   always_comb begin
      case (p_ff)
         2'd0:    begin b_idx = 2'd1; c_idx = 2'd2; d_idx = 2'd3; end
         2'd1:    begin b_idx = 2'd2; c_idx = 2'd1; d_idx = 2'd3; end
         default: begin b_idx = 2'd3; c_idx = 2'd1; d_idx = 2'd2; end
      endcase
      case (k_ff)
         2'd0:    begin x_idx = 2'd1; y_idx = 2'd2; end
         2'd1:    begin x_idx = 2'd2; y_idx = 2'd0; end
         default: begin x_idx = 2'd0; y_idx = 2'd1; end
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         u[k] = DW'(quad[0][k]) - DW'(quad[b_idx][k]);
         v[k] = DW'(quad[c_idx][k]) - DW'(quad[d_idx][k]);
      end
   end

   assign hi_op = MW'({1'b0, mag_ff[MAGW-1:H]});
   assign lo_op = MW'({1'b0, mag_ff[H-1:0]});

   always_comb begin
      case (op_ff)
         3'd0:    begin op_a = MW'(u[x_idx]); op_b = MW'(v[y_idx]); end
         3'd1:    begin op_a = MW'(u[y_idx]); op_b = MW'(v[x_idx]); end
         3'd2:    begin op_a = hi_op; op_b = hi_op; end
         3'd3:    begin op_a = hi_op; op_b = lo_op; end
         default: begin op_a = lo_op; op_b = lo_op; end
      endcase
   end

   cmsr_mul #(.WIDTH(MW)) u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign diff   = comp_ff - prod;
   assign prod_w = {{(SUMW-PW){1'b0}}, prod};

   // The last square of the last component of a pair, and of the last pair.
   assign last_term = (op_ff == 3'd4) && (k_ff == 2'd2);
   assign finish    = busy_ff && ph_ff && last_term && (p_ff == 2'd2);

   always_comb begin
      case (op_ff)
         3'd2:    sum_new = sum_ff + (prod_w << (2 * H));
         3'd3:    sum_new = sum_ff + (prod_w << (H + 1));
         default: sum_new = sum_ff + prod_w;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= finish && !ctl.start;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            p_ff    <= '0;
            k_ff    <= '0;
            op_ff   <= '0;
            ph_ff   <= 1'b0;
            sum_ff  <= '0;
            area_ff <= '0;
         end else if (busy_ff) begin
            ph_ff <= ~ph_ff;
            if (ph_ff) begin
               // Use the product issued in the previous cycle.
               case (op_ff)
                  3'd0: comp_ff <= prod;
                  3'd1: mag_ff  <= diff[PW-1] ? MAGW'(-diff) : MAGW'(diff);
                  default: sum_ff <= last_term ? '0 : sum_new;
               endcase
               if (op_ff == 3'd4) begin
                  op_ff <= '0;
                  if (k_ff == 2'd2) begin
                     k_ff <= '0;
                     if (sum_new > area_ff) begin
                        area_ff <= sum_new;
                     end
                     if (p_ff == 2'd2) begin
                        busy_ff <= 1'b0;
                     end else begin
                        p_ff <= p_ff + 2'd1;
                     end
                  end else begin
                     k_ff <= k_ff + 2'd1;
                  end
               end else begin
                  op_ff <= op_ff + 3'd1;
               end
            end
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign score    = area_ff;

endmodule

// ===== rtl/contact_manifold_slot_replacer.sv =====
// Contact manifold slot replacer, top level: slot store, sequencer and stream ports.
// Depends on cmsr_pkg and instantiates the area unit cmsr_area.
//
// The block keeps up to four contacts (depth and local point) and takes one
// transaction at a time; req_tready is high only while it is idle. An add
// with a free slot or a remove goes from acceptance through the write, a scan
// of the four slots for the deepest slot and the output load; a clear or an
// unused mode skips the write. An add into a full store first scans the
// depths for the protected slot, then scores every unprotected slot with the
// area unit: one registered multiplier does 45 multiply/accumulate steps per
// slot, while the protected slot is skipped without being scored.
// The result waits in an output register until taken; the next transaction
// is accepted once it has been loaded there. Slots carry no reset; only slots
// below the count are ever read.
module contact_manifold_slot_replacer #(
   parameter int COORD_BITS = cmsr_pkg::COORD_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: contact_depth[16], point_x, point_y, point_z
   // [COORD_BITS each], remove_slot[2], zero fill to whole bytes.
   input  logic [((cmsr_pkg::DEPTH_BITS + 3*COORD_BITS + 2 + 7) / 8) * 8 - 1:0] req_tdata,
   // Fields from bit 0: mode[2].
   input  logic [cmsr_pkg::MODE_BITS-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // Fields from bit 0: written_slot[2], contact_count[3], deepest_slot[2],
   // store_empty[1].
   output logic [cmsr_pkg::RSP_BITS-1:0] rsp_tdata
);
   import cmsr_pkg::*;

   localparam int SUMW = 4 * COORD_BITS + 4;
   localparam int X_LO = DEPTH_BITS;
   localparam int Y_LO = DEPTH_BITS + COORD_BITS;
   localparam int Z_LO = DEPTH_BITS + 2 * COORD_BITS;
   localparam int R_LO = DEPTH_BITS + 3 * COORD_BITS;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PROT, ST_AREA_START, ST_AREA_WAIT, ST_WRITE, ST_DEEP, ST_RESP
   } state_type;

   state_type state_ff;

   logic [MODE_BITS-1:0]         mode_ff;
   logic signed [DEPTH_BITS-1:0] depth_ff, best_depth_ff, deep_val_ff;
   logic signed [COORD_BITS-1:0] pt_ff [3];
   logic [SLOT_BITS-1:0]         rslot_ff, idx_ff, protect_ff, pick_ff;
   logic [SLOT_BITS-1:0]         wslot_ff, deep_ff, written_ff;
   logic [COUNT_BITS-1:0]        count_ff;
   logic                         prot_valid_ff, full_ff, rsp_valid_ff;
   logic [SUMW-1:0]              best_score_ff;
   logic [RSP_BITS-1:0]          rsp_data_ff;

   // Slot store; no reset, written before it is read.
   logic signed [DEPTH_BITS-1:0] slot_depth_ff [SLOTS];
   logic signed [COORD_BITS-1:0] slot_point_ff [SLOTS][3];

   area_ctl_type                 area_ctl;
   area_sts_type                 area_sts;
   logic [SUMW-1:0]              area_score;
   logic signed [COORD_BITS-1:0] quad [4][3];
   logic [SLOT_BITS-1:0]         other [3];
   logic [SLOT_BITS-1:0]         last_slot, wslot;
   logic                         in_accept, load_rsp;

   assign in_accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign load_rsp = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready);
   assign last_slot = SLOT_BITS'(count_ff - COUNT_BITS'(1));
   assign wslot = full_ff ? pick_ff : wslot_ff;

   // The new point and the three stored points other than the candidate slot.
   always_comb begin
      for (int n = 0; n < 3; n++) begin
         other[n] = (SLOT_BITS'(n) < idx_ff) ? SLOT_BITS'(n) : SLOT_BITS'(n + 1);
      end
      for (int k = 0; k < 3; k++) begin
         quad[0][k] = pt_ff[k];
         for (int n = 0; n < 3; n++) begin
            quad[n + 1][k] = slot_point_ff[other[n]][k];
         end
      end
   end

   assign area_ctl.start = (state_ff == ST_AREA_START) &&
                           !(prot_valid_ff && idx_ff == protect_ff);

   cmsr_area #(.COORD_BITS(COORD_BITS)) u_area (
      .clock (clock),
      .reset (reset),
      .ctl   (area_ctl),
      .quad  (quad),
      .sts   (area_sts),
      .score (area_score)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (rsp_valid_ff && !rsp_tready) || load_rsp;
         case (state_ff)
            ST_IDLE: begin
               if (in_accept) begin
                  mode_ff    <= req_tuser;
                  depth_ff   <= req_tdata[DEPTH_BITS-1:0];
                  pt_ff[0]   <= req_tdata[X_LO +: COORD_BITS];
                  pt_ff[1]   <= req_tdata[Y_LO +: COORD_BITS];
                  pt_ff[2]   <= req_tdata[Z_LO +: COORD_BITS];
                  rslot_ff   <= req_tdata[R_LO +: SLOT_BITS];
                  written_ff <= '0;
                  full_ff    <= 1'b0;
                  idx_ff     <= '0;
                  case (req_tuser)
                     MODE_ADD: begin
                        if (count_ff < COUNT_BITS'(SLOTS)) begin
                           wslot_ff <= SLOT_BITS'(count_ff);
                           count_ff <= count_ff + COUNT_BITS'(1);
                           state_ff <= ST_WRITE;
                        end else begin
                           full_ff       <= 1'b1;
                           best_depth_ff <= req_tdata[DEPTH_BITS-1:0];
                           prot_valid_ff <= 1'b0;
                           state_ff      <= ST_PROT;
                        end
                     end
                     MODE_REMOVE: state_ff <= ST_WRITE;
                     MODE_CLEAR: begin
                        count_ff <= '0;
                        state_ff <= ST_DEEP;
                     end
                     default: state_ff <= ST_DEEP;
                  endcase
               end
            end
            ST_PROT: begin
               // The deepest slot that is deeper than the new contact; on a tie the earlier slot.
               if (slot_depth_ff[idx_ff] > best_depth_ff) begin
                  best_depth_ff <= slot_depth_ff[idx_ff];
                  protect_ff    <= idx_ff;
                  prot_valid_ff <= 1'b1;
               end
               idx_ff <= idx_ff + SLOT_BITS'(1);
               if (idx_ff == SLOT_BITS'(SLOTS - 1)) begin
                  best_score_ff <= '0;
                  pick_ff       <= '0;
                  state_ff      <= ST_AREA_START;
               end
            end
            ST_AREA_START: begin
               if (area_ctl.start) begin
                  state_ff <= ST_AREA_WAIT;
               end else begin
                  // The protected slot scores zero and cannot win over the best.
                  idx_ff <= idx_ff + SLOT_BITS'(1);
                  if (idx_ff == SLOT_BITS'(SLOTS - 1)) begin
                     state_ff <= ST_WRITE;
                  end
               end
            end
            ST_AREA_WAIT: begin
               if (area_sts.done) begin
                  if (area_score > best_score_ff) begin
                     best_score_ff <= area_score;
                     pick_ff       <= idx_ff;
                  end
                  idx_ff <= idx_ff + SLOT_BITS'(1);
                  state_ff <= (idx_ff == SLOT_BITS'(SLOTS - 1)) ? ST_WRITE : ST_AREA_START;
               end
            end
            ST_WRITE: begin
               if (mode_ff == MODE_ADD) begin
                  slot_depth_ff[wslot]    <= depth_ff;
                  slot_point_ff[wslot][0] <= pt_ff[0];
                  slot_point_ff[wslot][1] <= pt_ff[1];
                  slot_point_ff[wslot][2] <= pt_ff[2];
                  written_ff              <= wslot;
               end else if (COUNT_BITS'(rslot_ff) < count_ff) begin
                  // Remove: the last valid slot moves into the removed one.
                  slot_depth_ff[rslot_ff]    <= slot_depth_ff[last_slot];
                  slot_point_ff[rslot_ff][0] <= slot_point_ff[last_slot][0];
                  slot_point_ff[rslot_ff][1] <= slot_point_ff[last_slot][1];
                  slot_point_ff[rslot_ff][2] <= slot_point_ff[last_slot][2];
                  count_ff                   <= count_ff - COUNT_BITS'(1);
               end
               idx_ff   <= '0;
               state_ff <= ST_DEEP;
            end
            ST_DEEP: begin
               if (COUNT_BITS'(idx_ff) < count_ff) begin
                  if (idx_ff == '0) begin
                     deep_val_ff <= slot_depth_ff[0];
                     deep_ff     <= '0;
                  end else if (slot_depth_ff[idx_ff] > deep_val_ff) begin
                     deep_val_ff <= slot_depth_ff[idx_ff];
                     deep_ff     <= idx_ff;
                  end
               end else if (idx_ff == '0) begin
                  deep_ff <= '0;
               end
               idx_ff <= idx_ff + SLOT_BITS'(1);
               if (idx_ff == SLOT_BITS'(SLOTS - 1)) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (load_rsp) begin
                  rsp_data_ff <= {(count_ff == '0), deep_ff, count_ff, written_ff};
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The store never holds more than four contacts.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(SLOTS))
      else $error("contact count above the slot count");

   // The area unit is never busy while a new transaction can be accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !area_sts.busy)
      else $error("area unit busy while idle");

   // An accepted transaction makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      in_accept |=> !req_tready)
      else $error("ready stayed high after acceptance");

   // The area unit reports completion only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      area_sts.done |-> (state_ff == ST_AREA_WAIT))
      else $error("area result outside the wait state");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for contact_manifold_slot_replacer. Depends on cmsr_pkg.
// Drives directed and random contact transactions, predicts each status result
// with its own slot model unless a directed row fixes it; compares field by field.
`timescale 1ns / 1ps

module testbench;
   import cmsr_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;
   localparam int REQ_W       = ((DEPTH_BITS + 3*16 + 2 + 7) / 8) * 8;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 800;

   // Status result, declared so that written_slot lands in the lowest bits.
   typedef struct packed {
      logic                  store_empty;
      logic [SLOT_BITS-1:0]  deepest_slot;
      logic [COUNT_BITS-1:0] contact_count;
      logic [SLOT_BITS-1:0]  written_slot;
   } status_type;

   typedef struct {
      logic [MODE_BITS-1:0] mode;
      logic signed [15:0]   depth;
      logic signed [15:0]   px, py, pz;
      logic [1:0]           remove_slot;
      bit                   has_fixed;
      status_type           fixed;
   } contact_req_type;

   typedef longint vec3_type [3];

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [MODE_BITS-1:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;

   // Side information that travels with the offered transaction.
   bit         cur_has_fixed;
   status_type cur_fixed;

   int unsigned send_idle_pct, recv_stall_pct;
   logic hold_go;
   int   hold_left;
   int   errors;
   int   quiet_cycles;

   status_type       status_queue[$];
   contact_req_type  directed_rows[$];

   // Slot store of the predictor.
   longint   store_depth [SLOTS];
   vec3_type store_point [SLOTS];
   int       store_count;

   contact_manifold_slot_replacer dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Squared magnitude of (a-b) x (c-d), exact.
   function automatic logic [127:0] cross_area_sq(vec3_type a, vec3_type b,
                                                  vec3_type c, vec3_type d);
      longint u [3];
      longint v [3];
      longint comp [3];
      logic [127:0] mag, sum;
      sum = '0;
      for (int k = 0; k < 3; k++) begin
         u[k] = a[k] - b[k];
         v[k] = c[k] - d[k];
      end
      comp[0] = u[1]*v[2] - u[2]*v[1];
      comp[1] = u[2]*v[0] - u[0]*v[2];
      comp[2] = u[0]*v[1] - u[1]*v[0];
      for (int k = 0; k < 3; k++) begin
         mag = (comp[k] < 0) ? 128'(-comp[k]) : 128'(comp[k]);
         sum = sum + mag * mag;
      end
      return sum;
   endfunction

   // Largest of the three diagonal-pair areas of a quadrilateral.
   function automatic logic [127:0] quad_area(vec3_type p0, vec3_type p1,
                                              vec3_type p2, vec3_type p3);
      logic [127:0] best, cand;
      best = cross_area_sq(p0, p1, p2, p3);
      cand = cross_area_sq(p0, p2, p1, p3);
      if (cand > best) best = cand;
      cand = cross_area_sq(p0, p3, p1, p2);
      if (cand > best) best = cand;
      return best;
   endfunction

   // Slot chosen for replacement when the store is full.
   function automatic int replace_slot(longint depth, vec3_type pt);
      int protect, pick, n;
      longint best_depth;
      logic [127:0] score [SLOTS];
      logic [127:0] best;
      vec3_type others [3];
      protect = -1;
      best_depth = depth;
      pick = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (store_depth[i] > best_depth) begin
            best_depth = store_depth[i];
            protect = i;
         end
      end
      for (int i = 0; i < SLOTS; i++) begin
         score[i] = '0;
         if (i != protect) begin
            n = 0;
            for (int j = 0; j < SLOTS; j++) begin
               if (j != i) begin
                  others[n] = store_point[j];
                  n++;
               end
            end
            score[i] = quad_area(pt, others[0], others[1], others[2]);
         end
      end
      best = score[0];
      for (int i = 1; i < SLOTS; i++) begin
         if (score[i] > best) begin
            best = score[i];
            pick = i;
         end
      end
      return pick;
   endfunction

   // Applies one transaction to the slot store and returns its status.
   function automatic status_type predict_status(logic [MODE_BITS-1:0] mode,
                                                 logic [REQ_W-1:0] data);
      status_type st;
      longint depth, best;
      vec3_type pt;
      int slot, r, last;
      st = '0;
      if (mode == MODE_ADD) begin
         depth = longint'($signed(data[15:0]));
         pt[0] = longint'($signed(data[31:16]));
         pt[1] = longint'($signed(data[47:32]));
         pt[2] = longint'($signed(data[63:48]));
         if (store_count < SLOTS) begin
            slot = store_count;
            store_count++;
         end else begin
            slot = replace_slot(depth, pt);
         end
         store_depth[slot] = depth;
         store_point[slot] = pt;
         st.written_slot = slot[1:0];
      end else if (mode == MODE_REMOVE) begin
         r = int'(data[65:64]);
         if (r < store_count) begin
            last = store_count - 1;
            store_depth[r] = store_depth[last];
            store_point[r] = store_point[last];
            store_count--;
         end
      end else if (mode == MODE_CLEAR) begin
         store_count = 0;
      end
      if (store_count > 0) begin
         best = store_depth[0];
         for (int i = 1; i < store_count; i++) begin
            if (store_depth[i] > best) begin
               best = store_depth[i];
               st.deepest_slot = i[1:0];
            end
         end
      end
      st.contact_count = store_count[2:0];
      st.store_empty = (store_count == 0);
      return st;
   endfunction

   // Monitor: predicts at each accepted request, checks each accepted result,
   // and runs the watchdog on cycles where nothing moves.
   always @(posedge clock) begin
      status_type got, want, pred;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pred = predict_status(req_tuser, req_tdata);
            status_queue = {status_queue, (cur_has_fixed ? cur_fixed : pred)};
         end
         if (rsp_tvalid && rsp_tready) begin
            got = status_type'(rsp_tdata);
            if (status_queue.size() == 0) begin
               $error("result 0x%02h arrived with no transaction outstanding", rsp_tdata);
               errors++;
            end else begin
               want = status_queue.pop_front();
               if (got.written_slot !== want.written_slot) begin
                  $error("written_slot expected %0d got %0d", want.written_slot,
                         got.written_slot);
                  errors++;
               end
               if (got.contact_count !== want.contact_count) begin
                  $error("contact_count expected %0d got %0d", want.contact_count,
                         got.contact_count);
                  errors++;
               end
               if (got.deepest_slot !== want.deepest_slot) begin
                  $error("deepest_slot expected %0d got %0d", want.deepest_slot,
                         got.deepest_slot);
                  errors++;
               end
               if (got.store_empty !== want.store_empty) begin
                  $error("store_empty expected %0d got %0d", want.store_empty,
                         got.store_empty);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL contact_manifold_slot_replacer");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_go) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Offers one transaction, idling first at random, and waits for acceptance.
   task automatic send_contact(contact_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid    <= 1'b1;
      req_tuser     <= item.mode;
      req_tdata     <= {6'b0, item.remove_slot, item.pz, item.py, item.px, item.depth};
      cur_has_fixed <= item.has_fixed;
      cur_fixed     <= item.fixed;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic add_row(logic [MODE_BITS-1:0] mode, int depth, int px, int py, int pz,
                          int remove_slot, bit has_fixed = 0, status_type fixed = '0);
      contact_req_type item;
      item.mode = mode;
      item.depth = depth[15:0];
      item.px = px[15:0];
      item.py = py[15:0];
      item.pz = pz[15:0];
      item.remove_slot = remove_slot[1:0];
      item.has_fixed = has_fixed;
      item.fixed = fixed;
      directed_rows = {directed_rows, item};
   endtask

   function automatic logic signed [15:0] random_coord(bit narrow);
      if (narrow) return 16'($signed($urandom_range(16)) - 8);
      return 16'($urandom);
   endfunction

   // Random transaction: mostly adds so the store stays full and the area
   // replacement is exercised, with removes, clears and unused modes mixed in.
   function automatic contact_req_type random_contact();
      contact_req_type item;
      int unsigned roll;
      bit narrow;
      roll = $urandom_range(99);
      narrow = ($urandom_range(3) == 0);
      item.mode = (roll < 78) ? MODE_ADD : (roll < 90) ? MODE_REMOVE :
                  (roll < 95) ? MODE_CLEAR : MODE_UNUSED;
      item.depth = narrow ? 16'($urandom_range(3)) : 16'($urandom);
      item.px = random_coord(narrow);
      item.py = random_coord(narrow);
      item.pz = random_coord(narrow);
      item.remove_slot = 2'($urandom);
      item.has_fixed = 0;
      item.fixed = '0;
      return item;
   endfunction

   initial begin
      status_type empty_st, full_st;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      cur_has_fixed = 0;
      cur_fixed = '0;
      hold_go = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      errors = 0;
      quiet_cycles = 0;
      store_count = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The empty store reports written 0, count 0, deepest 0, empty.
      empty_st = '{store_empty: 1'b1, deepest_slot: 2'd0, contact_count: 3'd0,
                   written_slot: 2'd0};
      add_row(MODE_CLEAR, 0, 0, 0, 0, 0, 1, empty_st);
      add_row(MODE_REMOVE, 0, 0, 0, 0, 0, 1, empty_st);
      add_row(MODE_UNUSED, -1, -1, -1, -1, 3, 1, empty_st);
      // Filling the store in order; the first contact stays the deepest.
      add_row(MODE_ADD, 32767, -32768, 32767, 0, 0, 1, '{1'b0, 2'd0, 3'd1, 2'd0});
      add_row(MODE_ADD, -32768, 32767, -32768, -32768, 3, 1, '{1'b0, 2'd0, 3'd2, 2'd1});
      add_row(MODE_ADD, 0, 0, 0, 32767, 0, 1, '{1'b0, 2'd0, 3'd3, 2'd2});
      add_row(MODE_ADD, 100, 256, -256, 512, 0, 1, '{1'b0, 2'd0, 3'd4, 2'd3});
      // Full store: slot 0 is deeper than the newcomer and is protected.
      add_row(MODE_ADD, 50, 1000, 2000, -3000, 0);
      // Newcomer as deep as any slot: nothing is protected.
      add_row(MODE_ADD, 32767, -32768, -32768, -32768, 0);
      add_row(MODE_UNUSED, 5, 5, 5, 5, 1);
      // Remove the last slot, then the first one, then one beyond the count.
      add_row(MODE_REMOVE, 0, 0, 0, 0, 3);
      add_row(MODE_REMOVE, 0, 0, 0, 0, 0);
      add_row(MODE_REMOVE, 0, 0, 0, 0, 3);
      add_row(MODE_CLEAR, 0, 0, 0, 0, 0, 1, empty_st);
      // Four identical points: every score is zero, so slot 0 is overwritten
      // even though nothing is deeper.
      full_st = '{store_empty: 1'b0, deepest_slot: 2'd0, contact_count: 3'd4,
                  written_slot: 2'd0};
      for (int i = 0; i < 5; i++) add_row(MODE_ADD, 0, 7, 7, 7, 0);
      directed_rows[directed_rows.size()-1].has_fixed = 1;
      directed_rows[directed_rows.size()-1].fixed = full_st;
      // Ties on depth: the first deepest slot is the one reported.
      add_row(MODE_ADD, 0, -7, 9, 3, 0);
      add_row(MODE_REMOVE, 0, 0, 0, 0, 1);
      add_row(MODE_CLEAR, 0, 0, 0, 0, 2, 1, empty_st);
      foreach (directed_rows[i]) send_contact(directed_rows[i]);

      // Random part in four idling phases. Between phases the sender pauses
      // until every outstanding result has been taken.
      for (int phase = 0; phase < 4; phase++) begin
         req_tvalid <= 1'b0;
         wait (status_queue.size() == 0);
         @(posedge clock);
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default: begin send_idle_pct = 28; recv_stall_pct = 28; end
         endcase
         // Long receiver hold-off while the sender keeps offering, so the
         // output register fills and the input stalls.
         if (phase == 2) begin
            hold_go <= 1'b1;
            @(posedge clock);
            hold_go <= 1'b0;
         end
         for (int n = 0; n < 112; n++) send_contact(random_contact());
      end
      req_tvalid <= 1'b0;

      wait (status_queue.size() == 0);
      repeat (400) @(posedge clock);
      if (errors == 0) begin
         $display("PASS contact_manifold_slot_replacer");
      end else begin
         $display("FAIL contact_manifold_slot_replacer");
      end
      $finish;
   end

endmodule
